### design/segi_pkg.sv
// ----------------------------------------------------------------------------
// segi_pkg: shared types, widths and helpers for the segment intersection
// Holds the coordinate width, all derived datapath widths, pipeline
// latencies and the small geometric helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package segi_pkg;

  // Coordinate width of every input and point field.
  localparam int COORD_BITS = 16;

  // Datapath widths derived from the coordinate width.
  localparam int DIF_W = COORD_BITS + 1;          // coordinate difference
  localparam int PRD_W = 2 * DIF_W;               // difference product
  localparam int ORI_W = PRD_W + 1;               // orientation value, determinant
  localparam int CPR_W = 2 * COORD_BITS;          // coordinate product
  localparam int CA_W  = CPR_W + 1;               // line constant
  localparam int NP_W  = CA_W + DIF_W;            // numerator product
  localparam int N_W   = NP_W + 1;                // numerator
  localparam int T_W   = N_W + 2;                 // rounded dividend
  localparam int DV_W  = ORI_W + 1;               // doubled divisor magnitude
  localparam int Q_W   = COORD_BITS + 1;          // quotient before saturation

  // Pipeline latencies.
  localparam int FRONT_LAT = 5;
  localparam int DIV_LAT   = Q_W + 3;
  localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Flags that travel beside the numerators.
  typedef struct packed {
    logic hit;
    logic par;
  } segi_flags_t;

  // Orientation class: zero, positive or negative.
  localparam logic [1:0] ORI_ZERO = 2'd0;
  localparam logic [1:0] ORI_POS  = 2'd1;
  localparam logic [1:0] ORI_NEG  = 2'd2;

  function automatic logic [1:0] ori_code(input logic signed [ORI_W-1:0] v);
    logic [1:0] c;
    if (v == '0) begin
      c = ORI_ZERO;
    end else if (v[ORI_W-1]) begin
      c = ORI_NEG;
    end else begin
      c = ORI_POS;
    end
    return c;
  endfunction

  // True when point q lies in the bounding box of p and r.
  function automatic logic in_box(input coord_t px, input coord_t py,
                                  input coord_t qx, input coord_t qy,
                                  input coord_t rx, input coord_t ry);
    coord_t xlo, xhi, ylo, yhi;
    xlo = (px < rx) ? px : rx;
    xhi = (px < rx) ? rx : px;
    ylo = (py < ry) ? py : ry;
    yhi = (py < ry) ? ry : py;
    return (qx >= xlo) && (qx <= xhi) && (qy >= ylo) && (qy <= yhi);
  endfunction

endpackage

`default_nettype wire

### design/segment_intersection.sv
// ----------------------------------------------------------------------------
// segment_intersection: segment crossing test and line crossing point
// Top level: orientation front end followed by two divider lanes.
// ----------------------------------------------------------------------------
// One segment pair is accepted every cycle while the pipeline is not held. The
// first 5 stages are the front end: differences, products and numerators. The
// next 20 stages are the divider: sign and magnitude preparation, a range
// check for saturation, 17 stages that each settle one quotient bit, and the
// final clamp. The whole pipeline advances together; it holds while a
// finished result waits for out_ready.
`default_nettype none

module segment_intersection (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire segi_pkg::coord_t in_ax_start,
  input  wire segi_pkg::coord_t in_ay_start,
  input  wire segi_pkg::coord_t in_ax_end,
  input  wire segi_pkg::coord_t in_ay_end,
  input  wire segi_pkg::coord_t in_bx_start,
  input  wire segi_pkg::coord_t in_by_start,
  input  wire segi_pkg::coord_t in_bx_end,
  input  wire segi_pkg::coord_t in_by_end,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_crosses,
  output logic                  out_lines_parallel,
  output segi_pkg::coord_t      out_cross_x,
  output segi_pkg::coord_t      out_cross_y,
  output logic                  out_point_clipped
);

  localparam int TL = segi_pkg::TOTAL_LAT;
  localparam int DL = segi_pkg::DIV_LAT;
  localparam int NW = segi_pkg::N_W;
  localparam int OW = segi_pkg::ORI_W;

  // Pipeline advance: the last stage is empty or its beat is taken.
  logic ce;
  logic v_r [0:TL-1];

  assign ce = !v_r[TL-1] || out_ready;
  assign in_ready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TL; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (ce) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < TL; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  // Front end.
  logic signed [NW-1:0] nx, ny;
  logic signed [OW-1:0] det;
  segi_pkg::segi_flags_t flags;

  segi_front u_front (
    .clk   (clk),
    .ce    (ce),
    .x1    (in_ax_start),
    .y1    (in_ay_start),
    .x2    (in_ax_end),
    .y2    (in_ay_end),
    .x3    (in_bx_start),
    .y3    (in_by_start),
    .x4    (in_bx_end),
    .y4    (in_by_end),
    .nx    (nx),
    .ny    (ny),
    .det   (det),
    .flags (flags)
  );

  // Divider lanes for both coordinates.
  segi_pkg::coord_t qx, qy;
  logic clip_x, clip_y;

  segi_div u_div_x (
    .clk  (clk),
    .ce   (ce),
    .num  (nx),
    .den  (det),
    .quo  (qx),
    .clip (clip_x)
  );

  segi_div u_div_y (
    .clk  (clk),
    .ce   (ce),
    .num  (ny),
    .den  (det),
    .quo  (qy),
    .clip (clip_y)
  );

  // Flags ride beside the divider lanes.
  segi_pkg::segi_flags_t fl_r [0:DL-1];

  always_ff @(posedge clk) begin
    if (ce) begin
      fl_r[0] <= flags;
      for (int i = 1; i < DL; i++) begin
        fl_r[i] <= fl_r[i-1];
      end
    end
  end

  // Result beat: a parallel pair gives the origin and no clipping.
  assign out_valid = v_r[TL-1];
  assign out_crosses = fl_r[DL-1].hit;
  assign out_lines_parallel = fl_r[DL-1].par;
  assign out_cross_x = fl_r[DL-1].par ? '0 : qx;
  assign out_cross_y = fl_r[DL-1].par ? '0 : qy;
  assign out_point_clipped = !fl_r[DL-1].par && (clip_x || clip_y);

endmodule

`default_nettype wire

### design/segi_front.sv
// ----------------------------------------------------------------------------
// segi_front: orientation test and determinant numerators
// Five register stages: differences, products, orientation and line
// constants, hit flag with numerator products, and the final numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module segi_front (
  input  wire logic                              clk,
  input  wire logic                              ce,
  input  wire segi_pkg::coord_t                  x1,
  input  wire segi_pkg::coord_t                  y1,
  input  wire segi_pkg::coord_t                  x2,
  input  wire segi_pkg::coord_t                  y2,
  input  wire segi_pkg::coord_t                  x3,
  input  wire segi_pkg::coord_t                  y3,
  input  wire segi_pkg::coord_t                  x4,
  input  wire segi_pkg::coord_t                  y4,
  output logic signed [segi_pkg::N_W-1:0]        nx,
  output logic signed [segi_pkg::N_W-1:0]        ny,
  output logic signed [segi_pkg::ORI_W-1:0]      det,
  output segi_pkg::segi_flags_t                  flags
);

  localparam int DW = segi_pkg::DIF_W;
  localparam int PW = segi_pkg::PRD_W;
  localparam int OW = segi_pkg::ORI_W;
  localparam int CPW = segi_pkg::CPR_W;
  localparam int CAW = segi_pkg::CA_W;
  localparam int NPW = segi_pkg::NP_W;
  localparam int NW = segi_pkg::N_W;

  // Stage 1: coordinates and differences.
  segi_pkg::coord_t c1_x1_r, c1_y1_r, c1_x2_r, c1_y2_r;
  segi_pkg::coord_t c1_x3_r, c1_y3_r, c1_x4_r, c1_y4_r;
  logic signed [DW-1:0] dx21_r, dy21_r, dx32_r, dy32_r, dx42_r, dy42_r;
  logic signed [DW-1:0] dx43_r, dy43_r, dx14_r, dy14_r, dx24_r, dy24_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      c1_x1_r <= x1; c1_y1_r <= y1; c1_x2_r <= x2; c1_y2_r <= y2;
      c1_x3_r <= x3; c1_y3_r <= y3; c1_x4_r <= x4; c1_y4_r <= y4;
      dx21_r <= DW'(x2) - DW'(x1);
      dy21_r <= DW'(y2) - DW'(y1);
      dx32_r <= DW'(x3) - DW'(x2);
      dy32_r <= DW'(y3) - DW'(y2);
      dx42_r <= DW'(x4) - DW'(x2);
      dy42_r <= DW'(y4) - DW'(y2);
      dx43_r <= DW'(x4) - DW'(x3);
      dy43_r <= DW'(y4) - DW'(y3);
      dx14_r <= DW'(x1) - DW'(x4);
      dy14_r <= DW'(y1) - DW'(y4);
      dx24_r <= DW'(x2) - DW'(x4);
      dy24_r <= DW'(y2) - DW'(y4);
    end
  end

  // Stage 2: one multiplier per product, box tests.
  logic signed [PW-1:0] p1a_r, p1b_r, p2a_r, p2b_r, p3a_r, p3b_r, p4a_r, p4b_r;
  logic signed [PW-1:0] pda_r, pdb_r;
  logic signed [CPW-1:0] pca1_r, pca2_r, pcb1_r, pcb2_r;
  logic [3:0] box2_r;
  logic signed [DW-1:0] s2_dx21_r, s2_dy21_r, s2_dx43_r, s2_dy43_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      p1a_r <= dy21_r * dx32_r;
      p1b_r <= dx21_r * dy32_r;
      p2a_r <= dy21_r * dx42_r;
      p2b_r <= dx21_r * dy42_r;
      p3a_r <= dy43_r * dx14_r;
      p3b_r <= dx43_r * dy14_r;
      p4a_r <= dy43_r * dx24_r;
      p4b_r <= dx43_r * dy24_r;
      pda_r <= dx21_r * dy43_r;
      pdb_r <= dy21_r * dx43_r;
      pca1_r <= c1_x1_r * c1_y2_r;
      pca2_r <= c1_y1_r * c1_x2_r;
      pcb1_r <= c1_x3_r * c1_y4_r;
      pcb2_r <= c1_y3_r * c1_x4_r;
      box2_r[0] <= segi_pkg::in_box(c1_x1_r, c1_y1_r, c1_x3_r, c1_y3_r, c1_x2_r, c1_y2_r);
      box2_r[1] <= segi_pkg::in_box(c1_x1_r, c1_y1_r, c1_x4_r, c1_y4_r, c1_x2_r, c1_y2_r);
      box2_r[2] <= segi_pkg::in_box(c1_x3_r, c1_y3_r, c1_x1_r, c1_y1_r, c1_x4_r, c1_y4_r);
      box2_r[3] <= segi_pkg::in_box(c1_x3_r, c1_y3_r, c1_x2_r, c1_y2_r, c1_x4_r, c1_y4_r);
      s2_dx21_r <= dx21_r;
      s2_dy21_r <= dy21_r;
      s2_dx43_r <= dx43_r;
      s2_dy43_r <= dy43_r;
    end
  end

  // Stage 3: orientation classes, determinant and line constants.
  logic [1:0] o1_r, o2_r, o3_r, o4_r;
  logic [3:0] box3_r;
  logic signed [OW-1:0] det3_r;
  logic signed [CAW-1:0] ca_r, cb_r;
  logic signed [DW-1:0] s3_dx21_r, s3_dy21_r, s3_dx43_r, s3_dy43_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      o1_r <= segi_pkg::ori_code(OW'(p1a_r) - OW'(p1b_r));
      o2_r <= segi_pkg::ori_code(OW'(p2a_r) - OW'(p2b_r));
      o3_r <= segi_pkg::ori_code(OW'(p3a_r) - OW'(p3b_r));
      o4_r <= segi_pkg::ori_code(OW'(p4a_r) - OW'(p4b_r));
      det3_r <= OW'(pda_r) - OW'(pdb_r);
      ca_r <= CAW'(pca1_r) - CAW'(pca2_r);
      cb_r <= CAW'(pcb1_r) - CAW'(pcb2_r);
      box3_r <= box2_r;
      s3_dx21_r <= s2_dx21_r;
      s3_dy21_r <= s2_dy21_r;
      s3_dx43_r <= s2_dx43_r;
      s3_dy43_r <= s2_dy43_r;
    end
  end

  // Stage 4: intersection decision and numerator products.
  logic hit_nxt;
  logic hit4_r;
  logic signed [NPW-1:0] nxa_r, nxb_r, nya_r, nyb_r;
  logic signed [OW-1:0] det4_r;

  always_comb begin
    hit_nxt = ((o1_r != o2_r) && (o3_r != o4_r)) ||
              ((o1_r == segi_pkg::ORI_ZERO) && box3_r[0]) ||
              ((o2_r == segi_pkg::ORI_ZERO) && box3_r[1]) ||
              ((o3_r == segi_pkg::ORI_ZERO) && box3_r[2]) ||
              ((o4_r == segi_pkg::ORI_ZERO) && box3_r[3]);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      hit4_r <= hit_nxt;
      nxa_r <= s3_dx21_r * cb_r;
      nxb_r <= ca_r * s3_dx43_r;
      nya_r <= s3_dy21_r * cb_r;
      nyb_r <= ca_r * s3_dy43_r;
      det4_r <= det3_r;
    end
  end

  // Stage 5: numerators and parallel flag.
  logic signed [NW-1:0] nx_r, ny_r;
  logic signed [OW-1:0] det5_r;
  segi_pkg::segi_flags_t flags_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      nx_r <= NW'(nxa_r) - NW'(nxb_r);
      ny_r <= NW'(nya_r) - NW'(nyb_r);
      det5_r <= det4_r;
      flags_r.hit <= hit4_r;
      flags_r.par <= (det4_r == '0);
    end
  end

  assign nx = nx_r;
  assign ny = ny_r;
  assign det = det5_r;
  assign flags = flags_r;

endmodule

`default_nettype wire

### design/segi_div.sv
// ----------------------------------------------------------------------------
// segi_div: pipelined rounded and saturated divider
// Gives num/den rounded to nearest, ties away from zero, clamped to the
// coordinate range. One quotient bit is settled in each restoring step stage.
// ----------------------------------------------------------------------------
`default_nettype none

module segi_div (
  input  wire logic                              clk,
  input  wire logic                              ce,
  input  wire logic signed [segi_pkg::N_W-1:0]   num,
  input  wire logic signed [segi_pkg::ORI_W-1:0] den,
  output segi_pkg::coord_t                       quo,
  output logic                                   clip
);

  localparam int NW = segi_pkg::N_W;
  localparam int OW = segi_pkg::ORI_W;
  localparam int TW = segi_pkg::T_W;
  localparam int DVW = segi_pkg::DV_W;
  localparam int QW = segi_pkg::Q_W;
  localparam int CB = segi_pkg::COORD_BITS;

  // Prep stage: sign and magnitudes, dividend is 2|n| + |d|.
  logic [NW-1:0] mn;
  logic [OW-1:0] md;
  logic neg_p_r;
  logic [TW-1:0] t_p_r;
  logic [DVW-1:0] dv_p_r;

  always_comb begin
    mn = num[NW-1] ? NW'(-num) : NW'(num);
    md = den[OW-1] ? OW'(-den) : OW'(den);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      neg_p_r <= num[NW-1] ^ den[OW-1];
      t_p_r <= TW'({mn, 1'b0}) + TW'(md);
      dv_p_r <= {md, 1'b0};
    end
  end

  // Range stage: the quotient saturates when the dividend reaches 2|d|(lim+1).
  logic [TW-1:0] thr;
  logic [TW-1:0] rem_r [0:QW];
  logic [QW-1:0] q_r [0:QW];
  logic [DVW-1:0] dv_r [0:QW];
  logic neg_r [0:QW];
  logic ovf_r [0:QW];

  always_comb begin
    thr = (TW'(dv_p_r) << (CB - 1)) + (neg_p_r ? TW'(dv_p_r) : '0);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r[0] <= t_p_r;
      q_r[0] <= '0;
      dv_r[0] <= dv_p_r;
      neg_r[0] <= neg_p_r;
      ovf_r[0] <= (t_p_r >= thr);
    end
  end

  // Restoring steps, most significant quotient bit first.
  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [TW-1:0] shd;
    logic fit;
    always_comb begin
      shd = TW'(dv_r[i]) << (QW - 1 - i);
      fit = (rem_r[i] >= shd);
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[i+1] <= fit ? (rem_r[i] - shd) : rem_r[i];
        q_r[i+1] <= {q_r[i][QW-2:0], fit};
        dv_r[i+1] <= dv_r[i];
        neg_r[i+1] <= neg_r[i];
        ovf_r[i+1] <= ovf_r[i];
      end
    end
  end

  // Output stage: clamp and restore the sign.
  logic [QW-1:0] lim;
  logic [QW-1:0] qm;
  segi_pkg::coord_t quo_r;
  logic clip_r;

  always_comb begin
    lim = neg_r[QW] ? (QW'(1) << (CB - 1)) : ((QW'(1) << (CB - 1)) - QW'(1));
    qm = ovf_r[QW] ? lim : q_r[QW];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      quo_r <= neg_r[QW] ? CB'(-qm) : CB'(qm);
      clip_r <= ovf_r[QW];
    end
  end

  assign quo = quo_r;
  assign clip = clip_r;

endmodule

`default_nettype wire

### design/segi_checker.sv
// ----------------------------------------------------------------------------
// segi_checker: port-level checks for the segment intersection
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module segi_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic             out_lines_parallel,
  input wire segi_pkg::coord_t out_cross_x,
  input wire segi_pkg::coord_t out_cross_y,
  input wire logic             out_point_clipped
);

  localparam segi_pkg::coord_t CMAX = {1'b0, {(segi_pkg::COORD_BITS-1){1'b1}}};
  localparam segi_pkg::coord_t CMIN = {1'b1, {(segi_pkg::COORD_BITS-1){1'b0}}};

  // No result beat right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown after reset");

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cross_x) && $stable(out_cross_y))
    else $error("stalled result beat changed");

  // Parallel lines give the origin without clipping.
  a_parallel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lines_parallel |->
      out_cross_x == '0 && out_cross_y == '0 && !out_point_clipped)
    else $error("parallel result not at origin");

  // A clipped point has a coordinate on a range bound.
  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_clipped |->
      out_cross_x == CMAX || out_cross_x == CMIN ||
      out_cross_y == CMAX || out_cross_y == CMIN)
    else $error("clipped point not on a bound");

endmodule

bind segment_intersection segi_checker u_segi_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_lines_parallel (out_lines_parallel),
  .out_cross_x        (out_cross_x),
  .out_cross_y        (out_cross_y),
  .out_point_clipped  (out_point_clipped)
);

`default_nettype wire

### bench/segment_intersection_checker.sv
// ----------------------------------------------------------------------------
// segment_intersection_checker: scoreboard for the segment intersection block
// Watches both channels, works out the expected crossing result of every
// accepted segment pair and compares each output beat with it, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_checker (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_ready,
  input  wire segi_pkg::coord_t in_ax_start,
  input  wire segi_pkg::coord_t in_ay_start,
  input  wire segi_pkg::coord_t in_ax_end,
  input  wire segi_pkg::coord_t in_ay_end,
  input  wire segi_pkg::coord_t in_bx_start,
  input  wire segi_pkg::coord_t in_by_start,
  input  wire segi_pkg::coord_t in_bx_end,
  input  wire segi_pkg::coord_t in_by_end,
  input  wire logic             out_valid,
  input  wire logic             out_ready,
  input  wire logic             out_crosses,
  input  wire logic             out_lines_parallel,
  input  wire segi_pkg::coord_t out_cross_x,
  input  wire segi_pkg::coord_t out_cross_y,
  input  wire logic             out_point_clipped,
  output int                    fail_count,
  output int                    pending
);

  typedef struct {
    logic             crosses;
    logic             par;
    segi_pkg::coord_t cx;
    segi_pkg::coord_t cy;
    logic             clipped;
  } crossing_t;

  crossing_t crossing_q[$];

  initial fail_count = 0;
  assign pending = crossing_q.size();

  // Sign class of the turn p -> q -> r, computed exactly.
  function automatic int turn_sign(longint px, longint py, longint qx, longint qy,
                                   longint rx, longint ry);
    longint v;
    v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
    if (v == 0) return 0;
    return (v > 0) ? 1 : 2;
  endfunction

  // True when q lies in the bounding box spanned by p and r.
  function automatic bit within_box(longint px, longint py, longint qx, longint qy,
                                    longint rx, longint ry);
    longint xlo, xhi, ylo, yhi;
    xlo = (px < rx) ? px : rx;
    xhi = (px < rx) ? rx : px;
    ylo = (py < ry) ? py : ry;
    yhi = (py < ry) ? ry : py;
    return qx >= xlo && qx <= xhi && qy >= ylo && qy <= yhi;
  endfunction

  // Quotient rounded half away from zero, clamped to the coordinate range.
  function automatic segi_pkg::coord_t round_clamp(longint num, longint den,
                                                   inout logic clip);
    bit                neg;
    longint unsigned   n, d, q, lim;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (2 * n + d) / (2 * d);
    lim = 64'd1 << (segi_pkg::COORD_BITS - 1);
    if (!neg) lim = lim - 1;
    if (q > lim) begin
      clip = 1'b1;
      q = lim;
    end
    return neg ? segi_pkg::coord_t'(-longint'(q)) : segi_pkg::coord_t'(q);
  endfunction

  function automatic crossing_t predict_crossing(
      longint x1, longint y1, longint x2, longint y2,
      longint x3, longint y3, longint x4, longint y4);
    crossing_t r;
    int        o1, o2, o3, o4;
    longint    det, ca, cb, nx, ny;
    logic      clip;
    o1 = turn_sign(x1, y1, x2, y2, x3, y3);
    o2 = turn_sign(x1, y1, x2, y2, x4, y4);
    o3 = turn_sign(x3, y3, x4, y4, x1, y1);
    o4 = turn_sign(x3, y3, x4, y4, x2, y2);
    r.crosses = (o1 != o2 && o3 != o4) ||
                (o1 == 0 && within_box(x1, y1, x3, y3, x2, y2)) ||
                (o2 == 0 && within_box(x1, y1, x4, y4, x2, y2)) ||
                (o3 == 0 && within_box(x3, y3, x1, y1, x4, y4)) ||
                (o4 == 0 && within_box(x3, y3, x2, y2, x4, y4));
    det = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
    clip = 1'b0;
    r.par = (det == 0);
    r.cx = '0;
    r.cy = '0;
    if (!r.par) begin
      ca = x1 * y2 - y1 * x2;
      cb = x3 * y4 - y3 * x4;
      nx = ca * (x3 - x4) - (x1 - x2) * cb;
      ny = ca * (y3 - y4) - (y1 - y2) * cb;
      r.cx = round_clamp(nx, det, clip);
      r.cy = round_clamp(ny, det, clip);
    end
    r.clipped = clip;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Record the expectation of each accepted input beat.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      crossing_q.push_back(predict_crossing(in_ax_start, in_ay_start, in_ax_end,
                                            in_ay_end, in_bx_start, in_by_start,
                                            in_bx_end, in_by_end));
    end
  end

  // Compare each accepted output beat with the oldest expectation.
  always @(posedge clk) begin
    crossing_t w;
    if (rst_n && out_valid && out_ready) begin
      if (crossing_q.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        w = crossing_q.pop_front();
        if (out_crosses !== w.crosses)
          report_mismatch("crosses", out_crosses, w.crosses);
        if (out_lines_parallel !== w.par)
          report_mismatch("lines_parallel", out_lines_parallel, w.par);
        if (out_cross_x !== w.cx) report_mismatch("cross_x", out_cross_x, w.cx);
        if (out_cross_y !== w.cy) report_mismatch("cross_y", out_cross_y, w.cy);
        if (out_point_clipped !== w.clipped)
          report_mismatch("point_clipped", out_point_clipped, w.clipped);
      end
    end
  end

endmodule

`default_nettype wire

### bench/segment_intersection_tb.sv
// ----------------------------------------------------------------------------
// segment_intersection_tb: top of the segment intersection testbench
// Drives directed segment pairs, then random pairs through four flow-control
// phases, lets the checker score every result and prints the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 285;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  segi_pkg::coord_t in_ax_start = '0, in_ay_start = '0, in_ax_end = '0, in_ay_end = '0;
  segi_pkg::coord_t in_bx_start = '0, in_by_start = '0, in_bx_end = '0, in_by_end = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_crosses, out_lines_parallel, out_point_clipped;
  segi_pkg::coord_t out_cross_x, out_cross_y;
  int               fail_count, pending;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               quiet_cycles = 0;

  segment_intersection dut (.*);
  segment_intersection_checker checker_i (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver back-pressure follows the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: too long without any accepted beat ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("segment_intersection_tb: FAIL");
      $finish;
    end
  end

  // Present one segment pair and hold it until accepted.
  task automatic send_pair(segi_pkg::coord_t ax0, segi_pkg::coord_t ay0,
                           segi_pkg::coord_t ax1, segi_pkg::coord_t ay1,
                           segi_pkg::coord_t bx0, segi_pkg::coord_t by0,
                           segi_pkg::coord_t bx1, segi_pkg::coord_t by1);
    in_valid <= 1'b1;
    in_ax_start <= ax0; in_ay_start <= ay0; in_ax_end <= ax1; in_ay_end <= ay1;
    in_bx_start <= bx0; in_by_start <= by0; in_bx_end <= bx1; in_by_end <= by1;
    do @(posedge clk); while (!in_ready);
    // Sender idles each cycle with the phase's probability.
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  function automatic segi_pkg::coord_t near_coord(int span);
    return segi_pkg::coord_t'($urandom_range(2 * span) - span);
  endfunction

  // One random pair shaped toward a chosen geometric situation.
  task automatic send_random_pair();
    segi_pkg::coord_t p[8];
    int               kind, k, s;
    kind = $urandom_range(9);
    s = (kind < 5) ? 64 : 2000;
    foreach (p[i]) p[i] = near_coord(s);
    case (kind)
      0, 1: begin
        foreach (p[i]) p[i] = segi_pkg::coord_t'($urandom);
      end
      2: begin
        // Shared endpoint between the two segments.
        k = $urandom_range(1);
        p[4 + 2 * k] = p[0]; p[5 + 2 * k] = p[1];
      end
      3: begin
        // All four points on one horizontal line through the first point.
        k = $urandom_range(3, 1);
        for (int i = 1; i < 4; i++) begin
          p[2 * i] = p[0] + segi_pkg::coord_t'(k * near_coord(8));
          p[2 * i + 1] = p[1] + segi_pkg::coord_t'(near_coord(1) * p[2 * i] -
                                                   near_coord(1) * p[0]);
        end
        p[3] = p[1]; p[5] = p[1]; p[7] = p[1];
      end
      4: begin
        // Parallel: B is A shifted.
        p[6] = p[4] + (p[2] - p[0]); p[7] = p[5] + (p[3] - p[1]);
      end
      5: begin
        // Nearly parallel long segments so the point may land far away.
        p[0] = segi_pkg::coord_t'($urandom); p[1] = segi_pkg::coord_t'($urandom);
        p[2] = segi_pkg::coord_t'($urandom); p[3] = segi_pkg::coord_t'($urandom);
        p[6] = p[4] + (p[2] - p[0]) + near_coord(2);
        p[7] = p[5] + (p[3] - p[1]) + near_coord(2);
      end
      6: begin
        // Degenerate segment: both endpoints equal.
        p[2] = p[0]; p[3] = p[1];
      end
      default: ;
    endcase
    send_pair(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: range corners, crossings, touches, collinear and parallel cases.
    send_pair(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
              16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_pair(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_pair(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
              16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_pair(0, 0, 16, 16, 0, 16, 16, 0);
    send_pair(0, 0, 16, 0, 16, 0, 32, 16);
    send_pair(0, 0, 32, 0, 16, 0, 16, 16);
    send_pair(0, 0, 32, 0, 16, 0, 48, 0);
    send_pair(0, 0, 16, 0, 32, 0, 48, 0);
    send_pair(0, 0, 16, 0, 0, 16, 16, 16);
    send_pair(5, 5, 5, 5, 5, 5, 5, 5);
    send_pair(5, 5, 5, 5, 0, 0, 10, 10);
    send_pair(5, 6, 5, 6, 0, 0, 10, 10);
    send_pair(0, 0, 16'sh7fff, 1, 0, 1, 16'sh7ffe, 2);
    send_pair(0, 0, 16'sh8000, 1, 0, 1, 16'sh8001, 2);
    send_pair(0, 0, 3, 1, 1, 0, 0, 3);
    send_pair(-7, -3, 5, 9, 2, -8, -4, 11);
    send_pair(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
              16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
    send_pair(1, 1, 3, 3, 2, 2, 5, 5);
    send_pair(0, 0, 1, 2, 2, 4, 3, 6);
    send_pair(-1, -1, 1, 1, -1, 1, 1, -1);

    // Random: four flow-control phases.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 67 : (ph == 3) ? 38 : 0;
      recv_stall_pct = (ph == 2) ? 67 : (ph == 3) ? 38 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_random_pair();
      end
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;

    while (pending != 0) @(posedge clk);
    repeat (segi_pkg::TOTAL_LAT + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("segment_intersection_tb: PASS");
    end else begin
      $display("segment_intersection_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### segment_intersection.f
design/segi_pkg.sv
design/segi_front.sv
design/segi_div.sv
design/segment_intersection.sv
design/segi_checker.sv
bench/segment_intersection_checker.sv
bench/segment_intersection_tb.sv
